>>> design/prbw_pkg.sv
// ----------------------------------------------------------------------------
// prbw_pkg
// Shared types and constants for the prelu backward block with slope gradient.
// ----------------------------------------------------------------------------
`default_nettype none

package prbw_pkg;

   // field widths fixed by the interface
   localparam int ENTRY_W  = 6;
   localparam int DATA_W   = 16;
   localparam int ACC_W    = 48;
   localparam int ALPHA_W  = 7;
   localparam int PLANE_W  = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // request opcodes
   typedef enum logic [1:0] {
      OP_LOAD_SLOPE = 2'd0,
      OP_CLEAR      = 2'd1,
      OP_ELEMENT    = 2'd2,
      OP_READ_GRAD  = 2'd3
   } opcode_type;

   // result kinds
   localparam logic KIND_DX   = 1'b0;
   localparam logic KIND_GRAD = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_SIZE  = 2'd1;

   // request as held in the working stage
   typedef struct packed {
      opcode_type                 opcode;
      logic [ENTRY_W-1:0]         entry_index;
      logic signed [DATA_W-1:0]   x_value;
      logic signed [DATA_W-1:0]   dy_value;
   } item_type;

   // one result item
   typedef struct packed {
      logic                       result_kind;
      logic signed [ACC_W-1:0]    result_value;
      logic [ENTRY_W-1:0]         channel_index;
   } result_type;

endpackage

`default_nettype wire

>>> design/prelu_backward_with_slope_grad.sv
// ----------------------------------------------------------------------------
// prelu_backward_with_slope_grad
// PReLU backward pass with a per-channel slope table and per-channel
// saturating slope-gradient accumulators in Q4.12 / Q24.24 fixed point.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    opcode, entry_index, slope, x, dy
//   rsp      out        rsp_valid/stall    result_kind, result_value, channel
//   csr      in         csr_write_en       csr_index, csr_data
//
// one request per cycle while req_stall is low; a result goes through the
// slope/accumulator memory read, then arithmetic into the result register
// a clear blocks requests while the accumulator memory is swept to zero,
// one entry a cycle; after reset the same sweep runs
// rsp_stall holds the result register; the working stage still takes one
// more request before req_stall rises
// ----------------------------------------------------------------------------
`default_nettype none

module prelu_backward_with_slope_grad
   import prbw_pkg::*;
#(
   parameter int SLOPE_DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_opcode,
   input  wire logic [ENTRY_W-1:0]      req_entry_index,
   input  wire logic signed [DATA_W-1:0] req_slope_value,
   input  wire logic signed [DATA_W-1:0] req_x_value,
   input  wire logic signed [DATA_W-1:0] req_dy_value,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_result_kind,
   output logic signed [ACC_W-1:0]      rsp_result_value,
   output logic      [ENTRY_W-1:0]      rsp_channel_index,
   // register write port
   input  wire logic                    csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int AW = (SLOPE_DEPTH > 1) ? $clog2(SLOPE_DEPTH) : 1;
   localparam int IW = ((AW > ENTRY_W) ? AW : ENTRY_W) + 1;

   // configuration registers
   logic [ALPHA_W-1:0] alpha_count_ff, alpha_count_in;
   logic [PLANE_W-1:0] plane_size_ff, plane_size_in;

   // working stage
   logic               s1_valid_ff, s1_valid_in;
   item_type           s1_item_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic               s1_range_ff;
   logic [ENTRY_W-1:0] s1_chan_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff;

   // last accumulator write, for read-during-write forwarding
   logic               lw_valid_ff, lw_valid_in;
   logic [AW-1:0]      lw_addr_ff;
   logic [ACC_W-1:0]   lw_data_ff;

   // clearing sweep
   logic               sweep_active_ff, sweep_active_in;
   logic [AW-1:0]      sweep_addr_ff, sweep_addr_in;

   opcode_type         req_op;
   logic               accept;
   logic               req_in_range;
   logic [AW-1:0]      req_entry_addr;
   logic [AW-1:0]      channel;
   logic [AW-1:0]      acc_rd_addr;
   logic               s1_has_result;
   logic               s1_go;
   logic               s1_free;
   logic               s1_clear;
   logic               out_ld;
   logic [DATA_W-1:0]  slope_rd;
   logic [ACC_W-1:0]   acc_rd;
   logic [ACC_W-1:0]   acc_old;
   logic               acc_we_dp;
   logic [ACC_W-1:0]   acc_new;
   logic               acc_wr_en;
   logic [AW-1:0]      acc_wr_addr;
   logic [ACC_W-1:0]   acc_wr_data;
   result_type         dp_result;
   item_type           req_item;

   // register writes
   always_comb begin
      alpha_count_in = alpha_count_ff;
      plane_size_in  = plane_size_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ALPHA_COUNT: alpha_count_in = csr_data[ALPHA_W-1:0];
            CSR_PLANE_SIZE:  plane_size_in  = csr_data[PLANE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_count_ff <= ALPHA_W'(1);
         plane_size_ff  <= PLANE_W'(1);
      end else begin
         alpha_count_ff <= alpha_count_in;
         plane_size_ff  <= plane_size_in;
      end
   end

   // handshake and stage control
   assign req_op        = opcode_type'(req_opcode);
   assign out_ld        = !rsp_valid_ff || !rsp_stall;
   assign s1_has_result = (s1_item_ff.opcode == OP_ELEMENT)
                       || (s1_item_ff.opcode == OP_READ_GRAD);
   assign s1_go         = s1_valid_ff && (!s1_has_result || out_ld);
   assign s1_free       = !s1_valid_ff || s1_go;
   assign s1_clear      = s1_valid_ff && (s1_item_ff.opcode == OP_CLEAR);
   assign req_stall     = sweep_active_ff || s1_clear || !s1_free;
   assign accept        = req_valid && !req_stall;

   // entry address and range check
   assign req_in_range   = IW'(req_entry_index) < IW'(SLOPE_DEPTH);
   assign req_entry_addr = AW'(req_entry_index);
   assign acc_rd_addr    = (req_op == OP_READ_GRAD) ? req_entry_addr : channel;

   // channel sequencing
   prbw_chan_ctrl #(
      .SLOPE_DEPTH (SLOPE_DEPTH)
   ) u_chan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .alpha_count (alpha_count_ff),
      .plane_size  (plane_size_ff),
      .advance     (accept && (req_op == OP_ELEMENT)),
      .clear       (accept && (req_op == OP_CLEAR)),
      .channel     (channel)
   );

   // slope table, written on an in-range load and read on every accept
   prbw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOPE_DEPTH)
   ) u_slope_ram (
      .clock   (clock),
      .wr_en   (accept && (req_op == OP_LOAD_SLOPE) && req_in_range),
      .wr_addr (req_entry_addr),
      .wr_data (req_slope_value),
      .rd_en   (accept),
      .rd_addr (channel),
      .rd_data (slope_rd)
   );

   // accumulator memory write port: sweep or working stage update
   always_comb begin
      if (sweep_active_ff) begin
         acc_wr_en   = 1'b1;
         acc_wr_addr = sweep_addr_ff;
         acc_wr_data = '0;
      end else begin
         acc_wr_en   = s1_go && acc_we_dp;
         acc_wr_addr = s1_addr_ff;
         acc_wr_data = acc_new;
      end
   end

   prbw_ram #(
      .WIDTH (ACC_W),
      .DEPTH (SLOPE_DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (accept),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd)
   );

   // forward a write that landed on the read edge
   assign acc_old = (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : acc_rd;

   always_comb begin
      lw_valid_in = lw_valid_ff || acc_wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_wr_en) begin
         lw_addr_ff <= acc_wr_addr;
         lw_data_ff <= acc_wr_data;
      end
   end

   // clearing sweep after reset and after a clear request
   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_addr_in   = sweep_addr_ff;
      if (sweep_active_ff) begin
         if (sweep_addr_ff == AW'(SLOPE_DEPTH - 1)) begin
            sweep_active_in = 1'b0;
            sweep_addr_in   = '0;
         end else begin
            sweep_addr_in   = sweep_addr_ff + AW'(1);
         end
      end else if (s1_clear && s1_go) begin
         sweep_active_in = 1'b1;
         sweep_addr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_addr_ff   <= '0;
      end else begin
         sweep_active_ff <= sweep_active_in;
         sweep_addr_ff   <= sweep_addr_in;
      end
   end

   // working stage register
   always_comb begin
      req_item.opcode      = req_op;
      req_item.entry_index = req_entry_index;
      req_item.x_value     = req_x_value;
      req_item.dy_value    = req_dy_value;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= req_item;
         s1_addr_ff  <= acc_rd_addr;
         s1_range_ff <= req_in_range;
         s1_chan_ff  <= ENTRY_W'(channel);
      end
   end

   // arithmetic
   prbw_datapath u_datapath (
      .item     (s1_item_ff),
      .acc_old  (acc_old),
      .slope    (slope_rd),
      .in_range (s1_range_ff),
      .chan     (s1_chan_ff),
      .result   (dp_result),
      .acc_we   (acc_we_dp),
      .acc_new  (acc_new)
   );

   // result register
   always_comb begin
      if (s1_go && s1_has_result) begin
         rsp_valid_in = 1'b1;
      end else if (out_ld) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_has_result) begin
         rsp_data_ff <= dp_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_data_ff.result_kind;
   assign rsp_result_value  = rsp_data_ff.result_value;
   assign rsp_channel_index = rsp_data_ff.channel_index;

endmodule

`default_nettype wire

>>> design/prbw_ram.sv
// ----------------------------------------------------------------------------
// prbw_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prbw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/prbw_chan_ctrl.sv
// ----------------------------------------------------------------------------
// prbw_chan_ctrl
// Plane position and channel counters; the channel advances every plane_size
// elements and wraps at the effective slope count.
// ----------------------------------------------------------------------------
`default_nettype none

module prbw_chan_ctrl
   import prbw_pkg::*;
#(
   parameter int SLOPE_DEPTH = 64,
   localparam int AW = (SLOPE_DEPTH > 1) ? $clog2(SLOPE_DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [ALPHA_W-1:0] alpha_count,
   input  wire logic [PLANE_W-1:0] plane_size,
   input  wire logic               advance,
   input  wire logic               clear,
   output logic      [AW-1:0]      channel
);

   localparam int CW = $clog2(SLOPE_DEPTH + 1);
   localparam int EW = (CW > ALPHA_W) ? CW : ALPHA_W;

   logic [PLANE_W-1:0] pos_ff, pos_in;
   logic [AW-1:0]      chan_ff, chan_in;
   logic [PLANE_W-1:0] pos_inc;
   logic [PLANE_W-1:0] psize;
   logic [EW-1:0]      eff_count;
   logic [EW-1:0]      chan_inc;
   logic               plane_wrap;

   // effective limits: zero reads as one, slope count capped at table depth
   always_comb begin
      psize = (plane_size == '0) ? PLANE_W'(1) : plane_size;
      if (alpha_count == '0) begin
         eff_count = EW'(1);
      end else if (EW'(alpha_count) > EW'(SLOPE_DEPTH)) begin
         eff_count = EW'(SLOPE_DEPTH);
      end else begin
         eff_count = EW'(alpha_count);
      end
   end

   // next position and channel
   always_comb begin
      pos_inc    = pos_ff + PLANE_W'(1);
      plane_wrap = (pos_inc >= psize) || (pos_inc == '0);
      chan_inc   = EW'(chan_ff) + EW'(1);
      pos_in     = pos_ff;
      chan_in    = chan_ff;
      if (clear) begin
         pos_in  = '0;
         chan_in = '0;
      end else if (advance) begin
         if (plane_wrap) begin
            pos_in  = '0;
            chan_in = (chan_inc >= eff_count) ? '0 : AW'(chan_inc);
         end else begin
            pos_in  = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         chan_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         chan_ff <= chan_in;
      end
   end

   assign channel = chan_ff;

endmodule

`default_nettype wire

>>> design/prbw_datapath.sv
// ----------------------------------------------------------------------------
// prbw_datapath
// Element and readout arithmetic: dx with floor shift and saturation, and the
// saturating slope-gradient accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module prbw_datapath
   import prbw_pkg::*;
(
   input  wire item_type              item,
   input  wire logic [ACC_W-1:0]      acc_old,
   input  wire logic [DATA_W-1:0]     slope,
   input  wire logic                  in_range,
   input  wire logic [ENTRY_W-1:0]    chan,
   output result_type                 result,
   output logic                       acc_we,
   output logic      [ACC_W-1:0]      acc_new
);

   logic signed [2*DATA_W-1:0] dx_prod;
   logic signed [2*DATA_W-1:0] grad_prod;
   logic signed [19:0]         dx_shift;
   logic signed [DATA_W-1:0]   dx_sat;
   logic signed [DATA_W-1:0]   dx;
   logic signed [ACC_W:0]      acc_sum;
   logic                       x_pos;

   // both products in parallel
   assign dx_prod   = item.dy_value * $signed(slope);
   assign grad_prod = item.x_value * item.dy_value;
   assign x_pos     = !item.x_value[DATA_W-1] && (item.x_value != '0);

   // dx: drop 12 fraction bits (floor), then clamp to 16 bits
   always_comb begin
      dx_shift = dx_prod[2*DATA_W-1:12];
      if (dx_shift[19:15] == 5'b00000 || dx_shift[19:15] == 5'b11111) begin
         dx_sat = dx_shift[15:0];
      end else if (dx_shift[19]) begin
         dx_sat = 16'sh8000;
      end else begin
         dx_sat = 16'sh7fff;
      end
      dx = x_pos ? item.dy_value : dx_sat;
   end

   // accumulate x*dy with 48-bit saturation
   always_comb begin
      acc_sum = {acc_old[ACC_W-1], acc_old}
              + {{(ACC_W + 1 - 2*DATA_W){grad_prod[2*DATA_W-1]}}, grad_prod};
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_new = acc_sum[ACC_W-1:0];
      end
      acc_we = (item.opcode == OP_ELEMENT) && !x_pos;
   end

   // result item
   always_comb begin
      if (item.opcode == OP_READ_GRAD) begin
         result.result_kind   = KIND_GRAD;
         result.result_value  = in_range ? acc_old : '0;
         result.channel_index = item.entry_index;
      end else begin
         result.result_kind   = KIND_DX;
         result.result_value  = {{(ACC_W - DATA_W){dx[DATA_W-1]}}, dx};
         result.channel_index = chan;
      end
   end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prelu backward block with slope gradient: a
// directed table, a slope preload, a run of extreme products on two channels,
// then random phases under several idle and stall mixes, checked against a
// predictor or, in the directed table, against fixed expected results.
// ----------------------------------------------------------------------------

module tb_top;
   import prbw_pkg::*;

   localparam int SLOPE_DEPTH   = 64;
   localparam int SETTLE_CYCLES = SLOPE_DEPTH + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int EXTREME_PAIRS = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam longint ACC_MAX = 64'sd140737488355327;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   // register indexes past the last real register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      opcode_type                opcode;
      logic [ENTRY_W-1:0]        entry;
      logic signed [DATA_W-1:0]  slope;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  dy;
   } stim_item_type;

   typedef struct packed {
      stim_item_type req;
      bit            has_fixed;
      result_type    fixed;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_opcode = '0;
   logic [ENTRY_W-1:0]           req_entry_index = '0;
   logic signed [DATA_W-1:0]     req_slope_value = '0;
   logic signed [DATA_W-1:0]     req_x_value = '0;
   logic signed [DATA_W-1:0]     req_dy_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_result_kind;
   logic signed [ACC_W-1:0]      rsp_result_value;
   logic [ENTRY_W-1:0]           rsp_channel_index;
   logic                         csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_data = '0;

   // predictor state
   logic signed [DATA_W-1:0]     slope_mem [SLOPE_DEPTH];
   logic signed [ACC_W-1:0]      accum_mem [SLOPE_DEPTH];
   int unsigned                  plane_pos;
   int unsigned                  chan_cnt;
   logic [ALPHA_W-1:0]           alpha_reg;
   logic [PLANE_W-1:0]           plane_reg;

   result_type                   pending_results [$];
   stim_row_type                 directed_rows [$];
   int                           send_idle_pct = 0;
   int                           recv_stall_pct = 0;
   logic                         hold_go = 1'b0;
   logic                         long_hold = 1'b0;
   int unsigned                  cycle_count = 0;
   int                           error_count = 0;

   prelu_backward_with_slope_grad #(.SLOPE_DEPTH(SLOPE_DEPTH)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_slope_value   (req_slope_value),
      .req_x_value       (req_x_value),
      .req_dy_value      (req_dy_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_result_value  (rsp_result_value),
      .rsp_channel_index (rsp_channel_index),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   always begin
      do @(posedge clock); while (!hold_go);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                  input logic [ACC_W-1:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // result checker, sampled mid-cycle so values are those seen at the next edge
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected", rsp_result_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.result_kind)
               report_mismatch("result_kind", ACC_W'(rsp_result_kind),
                               ACC_W'(want.result_kind));
            if (rsp_result_value !== want.result_value)
               report_mismatch("result_value", rsp_result_value, want.result_value);
            if (rsp_channel_index !== want.channel_index)
               report_mismatch("channel_index", ACC_W'(rsp_channel_index),
                               ACC_W'(want.channel_index));
         end
      end
   end

   // prelu backward prediction: updates state, returns 1 when a result is due
   function automatic bit compute_prelu_grad(input stim_item_type r, output result_type res);
      bit          produced;
      int unsigned ch;
      int unsigned alpha_lim;
      int unsigned plane_lim;
      longint      prod;
      longint      dx;
      longint      sum;
      produced = 1'b0;
      res = '0;
      case (r.opcode)
         OP_LOAD_SLOPE: slope_mem[r.entry] = r.slope;
         OP_CLEAR: begin
            foreach (accum_mem[i]) accum_mem[i] = '0;
            plane_pos = 0;
            chan_cnt = 0;
         end
         OP_READ_GRAD: begin
            res.result_kind = KIND_GRAD;
            res.result_value = accum_mem[r.entry];
            res.channel_index = r.entry;
            produced = 1'b1;
         end
         default: begin
            ch = chan_cnt % SLOPE_DEPTH;
            if (r.x > 0) begin
               dx = longint'(r.dy);
            end else begin
               // floor shift of the Q8.24 product, then clamp to 16 bits
               prod = longint'(r.dy) * longint'(slope_mem[ch]);
               dx = prod >>> 12;
               if (dx > 32767) dx = 32767;
               else if (dx < -32768) dx = -32768;
               sum = longint'(accum_mem[ch]) + longint'(r.x) * longint'(r.dy);
               if (sum > ACC_MAX) sum = ACC_MAX;
               else if (sum < ACC_MIN) sum = ACC_MIN;
               accum_mem[ch] = sum[ACC_W-1:0];
            end
            res.result_kind = KIND_DX;
            res.result_value = dx[ACC_W-1:0];
            res.channel_index = ch[ENTRY_W-1:0];
            produced = 1'b1;
            // plane position and channel advance
            alpha_lim = (alpha_reg == 0) ? 1 :
                        (alpha_reg > SLOPE_DEPTH) ? SLOPE_DEPTH : alpha_reg;
            plane_lim = (plane_reg == 0) ? 1 : plane_reg;
            plane_pos = (plane_pos + 1) & 24'hFFFFFF;
            if (plane_pos >= plane_lim || plane_pos == 0) begin
               plane_pos = 0;
               chan_cnt++;
               if (chan_cnt >= alpha_lim) chan_cnt = 0;
            end
         end
      endcase
      return produced;
   endfunction

   function automatic stim_item_type make_request(input opcode_type op,
                                                  input logic [ENTRY_W-1:0] entry,
                                                  input logic signed [DATA_W-1:0] slope,
                                                  input logic signed [DATA_W-1:0] x,
                                                  input logic signed [DATA_W-1:0] dy);
      stim_item_type r;
      r.opcode = op;
      r.entry = entry;
      r.slope = slope;
      r.x = x;
      r.dy = dy;
      return r;
   endfunction

   // Q4.12 value, biased toward the extremes and zero
   function automatic logic signed [DATA_W-1:0] pick_q412();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(15))
         0: v = -16'sd32768;
         1: v = 16'sd32767;
         2: v = '0;
         3: v = 16'sd1;
         4: v = -16'sd1;
         default: v = DATA_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic stim_item_type random_request();
      int            roll;
      stim_item_type r;
      roll = $urandom_range(99);
      r = make_request(OP_ELEMENT, ENTRY_W'($urandom), pick_q412(), pick_q412(),
                       pick_q412());
      if (roll < 2) r.opcode = OP_CLEAR;
      else if (roll < 10) r.opcode = OP_LOAD_SLOPE;
      else if (roll < 20) r.opcode = OP_READ_GRAD;
      return r;
   endfunction

   // drive one request, wait for acceptance, queue its expected result
   task automatic send_request(input stim_item_type r, input bit use_fixed,
                               input result_type fixed);
      result_type predicted;
      bit         produced;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_entry_index <= r.entry;
      req_slope_value <= r.slope;
      req_x_value <= r.x;
      req_dy_value <= r.dy;
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      produced = compute_prelu_grad(r, predicted);
      if (produced) pending_results.push_back(use_fixed ? fixed : predicted);
   endtask

   task automatic send_plain(input stim_item_type r);
      send_request(r, 1'b0, '0);
   endtask

   // stop offering, wait for every result and for a clear sweep to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_ALPHA_COUNT: alpha_reg = data[ALPHA_W-1:0];
         CSR_PLANE_SIZE:  plane_reg = data[PLANE_W-1:0];
         default: ;
      endcase
   endtask

   // register update while the block is idle; upper alpha word bits are junk
   task automatic write_registers(input logic [ALPHA_W-1:0] alpha,
                                  input logic [PLANE_W-1:0] plane, input bit with_spare);
      logic [CSR_DATA_W-1:0] word;
      settle();
      if (with_spare) begin
         csr_write(CSR_SPARE_A, CSR_DATA_W'($urandom));
         csr_write(CSR_SPARE_B, CSR_DATA_W'($urandom));
      end
      word = CSR_DATA_W'($urandom);
      word[ALPHA_W-1:0] = alpha;
      csr_write(CSR_ALPHA_COUNT, word);
      csr_write(CSR_PLANE_SIZE, plane);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_plain(random_request());
   endtask

   task automatic add_row(input stim_item_type r, input bit has_fixed, input logic kind,
                          input longint value, input logic [ENTRY_W-1:0] ch);
      stim_row_type row;
      row.req = r;
      row.has_fixed = has_fixed;
      row.fixed.result_kind = kind;
      row.fixed.result_value = value[ACC_W-1:0];
      row.fixed.channel_index = ch;
      directed_rows.push_back(row);
   endtask

   initial begin
      int waited;
      foreach (slope_mem[i]) slope_mem[i] = '0;
      foreach (accum_mem[i]) accum_mem[i] = '0;
      plane_pos = 0;
      chan_cnt = 0;
      alpha_reg = 1;
      plane_reg = 1;

      // directed table, run at the reset register values (one channel)
      add_row(make_request(OP_READ_GRAD, 0, 0, 0, 0), 1, KIND_GRAD, 0, 0);
      add_row(make_request(OP_READ_GRAD, 63, 0, 0, 0), 1, KIND_GRAD, 0, 63);
      add_row(make_request(OP_LOAD_SLOPE, 0, 16'sh1000, 0, 0), 0, KIND_DX, 0, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, 16'sh1000, -16'sd32768), 1, KIND_DX, -32768, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, 16'sd32767, 16'sd32767), 1, KIND_DX, 32767, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, 0, 16'sh1000), 1, KIND_DX, 4096, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, -16'sd32768, -16'sd1), 1, KIND_DX, -1, 0);
      add_row(make_request(OP_READ_GRAD, 0, 0, 0, 0), 1, KIND_GRAD, 32768, 0);
      add_row(make_request(OP_LOAD_SLOPE, 0, -16'sd32768, 0, 0), 0, KIND_DX, 0, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, -16'sd1, -16'sd32768), 1, KIND_DX, 32767, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, -16'sd1, 16'sd32767), 1, KIND_DX, -32768, 0);
      add_row(make_request(OP_LOAD_SLOPE, 0, 16'sd1, 0, 0), 0, KIND_DX, 0, 0);
      // tiny products: the shift rounds toward minus infinity
      add_row(make_request(OP_ELEMENT, 0, 0, -16'sd1, -16'sd1), 1, KIND_DX, -1, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, -16'sd1, 16'sd1), 1, KIND_DX, 0, 0);
      add_row(make_request(OP_READ_GRAD, 0, 0, 0, 0), 1, KIND_GRAD, 32769, 0);
      add_row(make_request(OP_LOAD_SLOPE, 63, 16'sd32767, 0, 0), 0, KIND_DX, 0, 0);
      // clear keeps the slopes, zeroes the sums
      add_row(make_request(OP_CLEAR, 0, 0, 0, 0), 0, KIND_DX, 0, 0);
      add_row(make_request(OP_READ_GRAD, 0, 0, 0, 0), 1, KIND_GRAD, 0, 0);
      add_row(make_request(OP_READ_GRAD, 63, 0, 0, 0), 1, KIND_GRAD, 0, 63);
      add_row(make_request(OP_LOAD_SLOPE, 0, 16'sd32767, 0, 0), 0, KIND_DX, 0, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, -16'sd32768, 16'sd32767), 1, KIND_DX, 32767, 0);
      add_row(make_request(OP_READ_GRAD, 0, 0, 0, 0), 1, KIND_GRAD, -1073709056, 0);
      add_row(make_request(OP_ELEMENT, 0, 0, 16'sd1, 16'sd12345), 1, KIND_DX, 12345, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_fixed,
                      directed_rows[i].fixed);

      // every slope entry gets a value before channels are spread out
      for (int i = 0; i < SLOPE_DEPTH; i++)
         send_plain(make_request(OP_LOAD_SLOPE, ENTRY_W'(i), pick_q412(), 0, 0));

      // largest products of both signs piling up on two channels
      write_registers(7'd2, 24'd1, 1'b0);
      send_plain(make_request(OP_CLEAR, 0, 0, 0, 0));
      send_plain(make_request(OP_LOAD_SLOPE, 0, -16'sd32768, 0, 0));
      send_plain(make_request(OP_LOAD_SLOPE, 1, 16'sd32767, 0, 0));
      for (int i = 0; i < EXTREME_PAIRS; i++) begin
         send_plain(make_request(OP_ELEMENT, 0, 0, -16'sd32768, -16'sd32768));
         send_plain(make_request(OP_ELEMENT, 0, 0, -16'sd32768, 16'sd32767));
      end
      send_plain(make_request(OP_READ_GRAD, 0, 0, 0, 0));
      send_plain(make_request(OP_READ_GRAD, 1, 0, 0, 0));

      // random phases under different register settings and traffic mixes
      write_registers(7'd64, 24'd1, 1'b1);
      random_phase(0, 0, 400);
      write_registers(7'd3, 24'd5, 1'b0);
      random_phase(66, 0, 350);
      write_registers(7'd0, 24'd0, 1'b0);
      random_phase(0, 66, 300);
      write_registers(7'd127, 24'd2, 1'b0);
      random_phase(21, 21, 300);

      // huge plane, no clears, so the position runs past the next limit
      write_registers(7'd64, 24'hFFFFFF, 1'b0);
      random_phase(0, 0, 0);
      repeat (100) send_plain(make_request(OP_ELEMENT, 0, 0, pick_q412(), pick_q412()));
      write_registers(ALPHA_W'($urandom_range(64, 1)), PLANE_W'($urandom_range(9, 1)), 1'b0);
      random_phase(21, 21, 200);

      // receiver holds off while the sender keeps pushing, then sender pauses
      write_registers(7'd5, 24'd3, 1'b0);
      random_phase(0, 0, 0);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      repeat (40) send_plain(make_request(OP_ELEMENT, 0, 0, pick_q412(), pick_q412()));
      settle();
      random_phase(0, 0, 20);

      // drain and finish
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", ACC_W'(pending_results.size()), '0);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
